// ===== rtl/sliding_window_sender_fast_retransmit_defines.svh =====
// Assertion macros for the go-back-N sender checker.
// Included by the checker file only; relies on clk and rst_n in scope.
`ifndef SLIDING_WINDOW_SENDER_FAST_RETRANSMIT_DEFINES_SVH
`define SLIDING_WINDOW_SENDER_FAST_RETRANSMIT_DEFINES_SVH

// Clocked property, muted while reset is held
`define SWSFR_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked property that also holds through reset
`define SWSFR_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/swsfr_pkg.sv =====
// Shared types and constants for the go-back-N sender with fast retransmit.
// No dependencies; imported by every module and interface of the block.
`timescale 1ns / 1ps

package swsfr_pkg;

    // Sequence space; pointer arithmetic wraps naturally, so keep it a power of two
    localparam int SEQ_SPACE = 8;
    localparam int SEQ_W     = $clog2(SEQ_SPACE);

    localparam int FUNC_W  = 2;
    localparam int LIMIT_W = 3;
    localparam int THR_W   = 2;
    localparam int TIMER_W = 2;
    // In-flight count never exceeds the 3-bit window limit
    localparam int IF_W    = LIMIT_W;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = LIMIT_W;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LIMIT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DUP_THRESHOLD = 1'd1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 3'd4;
    localparam logic [THR_W-1:0]   THR_RESET   = 2'd3;

    // Input function codes
    localparam logic [FUNC_W-1:0] FUNC_SEND    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ACK     = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TIMEOUT = 2'd2;

    // Timer commands
    localparam logic [TIMER_W-1:0] TIMER_NONE  = 2'd0;
    localparam logic [TIMER_W-1:0] TIMER_START = 2'd1;
    localparam logic [TIMER_W-1:0] TIMER_STOP  = 2'd2;

    // Classified command handed from the front end to the back end
    typedef enum logic [1:0] {
        CMD_NOP,
        CMD_SEND,
        CMD_ACK,
        CMD_TIMEOUT
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [SEQ_W-1:0] ack;
    } cmd_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] window_limit;
        logic [THR_W-1:0]   dup_ack_threshold;
    } cfg_t;

endpackage

// ===== rtl/swsfr_in_if.sv =====
// Input channel of the sender: valid/ready handshake with the event fields.
// Depends on swsfr_pkg.
`timescale 1ns / 1ps

interface swsfr_in_if #(
    parameter int PAYLOAD_BITS = 64
);
    import swsfr_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [FUNC_W-1:0]       func;
    logic [PAYLOAD_BITS-1:0] payload_word;
    logic [SEQ_W-1:0]        ack_number;
    logic                    ack_checksum_ok;

    modport source (
        output valid, func, payload_word, ack_number, ack_checksum_ok,
        input  ready
    );

    modport sink (
        input  valid, func, payload_word, ack_number, ack_checksum_ok,
        output ready
    );

endinterface

// ===== rtl/swsfr_out_if.sv =====
// Result channel of the sender: valid/ready handshake with the result fields.
// Depends on swsfr_pkg.
`timescale 1ns / 1ps

interface swsfr_out_if #(
    parameter int PAYLOAD_BITS = 64
);
    import swsfr_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    accepted;
    logic                    tx_valid;
    logic [SEQ_W-1:0]        tx_seq;
    logic [PAYLOAD_BITS-1:0] tx_payload;
    logic [TIMER_W-1:0]      timer_cmd;
    logic [SEQ_W-1:0]        timer_seq;
    logic                    window_full;
    logic [SEQ_W-1:0]        window_base;
    logic [SEQ_W-1:0]        next_seq;

    modport source (
        output valid, accepted, tx_valid, tx_seq, tx_payload, timer_cmd, timer_seq,
               window_full, window_base, next_seq,
        input  ready
    );

    modport sink (
        input  valid, accepted, tx_valid, tx_seq, tx_payload, timer_cmd, timer_seq,
               window_full, window_base, next_seq,
        output ready
    );

endinterface

// ===== rtl/swsfr_front.sv =====
// Front end: accepts input beats, decodes them into commands, queues them.
// Depends on swsfr_pkg and swsfr_in_if.
`timescale 1ns / 1ps

module swsfr_front #(
    parameter int PAYLOAD_BITS = 64
) (
    input  logic                    clk,
    input  logic                    rst_n,
    swsfr_in_if.sink                ingress,
    output swsfr_pkg::cmd_t         cmd,
    output logic [PAYLOAD_BITS-1:0] cmd_payload,
    output logic                    cmd_valid,
    input  logic                    cmd_ready
);
    import swsfr_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = 1;
    localparam int CNT_W = 2;

    cmd_t                    q_cmd_reg     [DEPTH];
    logic [PAYLOAD_BITS-1:0] q_payload_reg [DEPTH];
    logic [PTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]        count_reg,  count_next;

    cmd_t decoded;
    logic push;
    logic pop;

    // Decode the function code; a failed checksum turns an ack into a no-op
    always_comb
    begin
        decoded.ack = ingress.ack_number;
        unique case (ingress.func)
            FUNC_SEND:    decoded.kind = CMD_SEND;
            FUNC_ACK:     decoded.kind = ingress.ack_checksum_ok ? CMD_ACK : CMD_NOP;
            FUNC_TIMEOUT: decoded.kind = CMD_TIMEOUT;
            default:      decoded.kind = CMD_NOP;
        endcase
    end

    assign ingress.ready = (count_reg != CNT_W'(DEPTH));
    assign push          = ingress.valid && ingress.ready;
    assign cmd_valid     = (count_reg != '0);
    assign pop           = cmd_valid && cmd_ready;

    assign cmd         = q_cmd_reg[rd_ptr_reg];
    assign cmd_payload = q_payload_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_cmd_reg[wr_ptr_reg]     <= decoded;
            q_payload_reg[wr_ptr_reg] <= ingress.payload_word;
        end
    end

endmodule

// ===== rtl/swsfr_back.sv =====
// Back end: window state, payload store and result register of the sender.
// Depends on swsfr_pkg and swsfr_out_if.
`timescale 1ns / 1ps

module swsfr_back #(
    parameter int WINDOW       = 4,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  swsfr_pkg::cfg_t         cfg,
    input  swsfr_pkg::cmd_t         cmd,
    input  logic [PAYLOAD_BITS-1:0] cmd_payload,
    input  logic                    cmd_valid,
    output logic                    cmd_ready,
    swsfr_out_if.source             egress
);
    import swsfr_pkg::*;

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int ADD_W  = SLOT_W + 1;
    localparam logic [IF_W-1:0] WIN_CAP = IF_W'((WINDOW > 7) ? 7 : WINDOW);

    // Window state
    logic [SEQ_W-1:0]  base_reg,  base_next;
    logic [SEQ_W-1:0]  nseq_reg,  nseq_next;
    logic [IF_W-1:0]   infl_reg,  infl_next;
    logic [THR_W-1:0]  dup_reg,   dup_next;
    logic [SLOT_W-1:0] head_reg,  head_next;

    logic [PAYLOAD_BITS-1:0] store_mem [WINDOW];

    // Result register
    logic                    out_valid_reg;
    logic                    accepted_reg,    accepted_next;
    logic                    tx_valid_reg,    tx_valid_next;
    logic [SEQ_W-1:0]        tx_seq_reg,      tx_seq_next;
    logic [PAYLOAD_BITS-1:0] tx_payload_reg,  tx_payload_next;
    logic [TIMER_W-1:0]      timer_cmd_reg,   timer_cmd_next;
    logic [SEQ_W-1:0]        timer_seq_reg,   timer_seq_next;
    logic                    full_reg,        full_next;

    logic              take;
    logic              store_we;
    logic              resend;
    logic [SLOT_W-1:0] store_slot;
    logic [IF_W-1:0]   eff_limit;
    logic [THR_W-1:0]  eff_thr;
    logic [SEQ_W-1:0]  prev_seq;
    logic [SEQ_W-1:0]  ack_span;
    logic [THR_W-1:0]  dup_inc;
    logic [ADD_W-1:0]  slot_sum;
    logic [ADD_W-1:0]  head_sum;

    // Slot index modulo WINDOW; the sum stays below twice the depth
    function automatic logic [SLOT_W-1:0] wrap_slot(input logic [ADD_W-1:0] sum);
        logic [ADD_W-1:0] adj;
        adj = (sum >= ADD_W'(WINDOW)) ? sum - ADD_W'(WINDOW) : sum;
        return adj[SLOT_W-1:0];
    endfunction

    assign cmd_ready = !out_valid_reg || egress.ready;
    assign take      = cmd_valid && cmd_ready;

    assign eff_limit = (cfg.window_limit == '0)    ? IF_W'(1) :
                       (cfg.window_limit > WIN_CAP) ? WIN_CAP : cfg.window_limit;
    assign eff_thr   = (cfg.dup_ack_threshold == '0) ? THR_W'(1) : cfg.dup_ack_threshold;

    assign prev_seq = base_reg - SEQ_W'(1);
    assign ack_span = cmd.ack + SEQ_W'(1) - base_reg;
    assign dup_inc  = dup_reg + THR_W'(1);
    assign slot_sum = ADD_W'(head_reg) + ADD_W'(infl_reg);
    assign head_sum = ADD_W'(head_reg) + ADD_W'(ack_span);

    always_comb
    begin
        base_next  = base_reg;
        nseq_next  = nseq_reg;
        infl_next  = infl_reg;
        dup_next   = dup_reg;
        head_next  = head_reg;
        store_we   = 1'b0;
        resend     = 1'b0;
        store_slot = wrap_slot(slot_sum);

        accepted_next   = 1'b0;
        tx_valid_next   = 1'b0;
        tx_seq_next     = '0;
        tx_payload_next = '0;
        timer_cmd_next  = TIMER_NONE;
        timer_seq_next  = '0;

        unique case (cmd.kind)
            CMD_SEND:
            begin
                if (infl_reg < eff_limit)
                begin
                    store_we        = 1'b1;
                    accepted_next   = 1'b1;
                    tx_valid_next   = 1'b1;
                    tx_seq_next     = nseq_reg;
                    tx_payload_next = cmd_payload;
                    if (infl_reg == '0)
                    begin
                        timer_cmd_next = TIMER_START;
                        timer_seq_next = nseq_reg;
                    end
                    infl_next = infl_reg + IF_W'(1);
                    nseq_next = nseq_reg + SEQ_W'(1);
                end
            end
            CMD_ACK:
            begin
                if (cmd.ack == prev_seq)
                begin
                    // Duplicate: count, and resend the oldest at the threshold
                    dup_next = dup_inc;
                    if (dup_inc >= eff_thr)
                    begin
                        dup_next = '0;
                        if (infl_reg != '0)
                        begin
                            tx_valid_next = 1'b1;
                            tx_seq_next   = base_reg;
                            resend        = 1'b1;
                        end
                    end
                end
                else if (ack_span != '0 && IF_W'(ack_span) <= infl_reg)
                begin
                    // New cumulative ack: slide the window
                    base_next = cmd.ack + SEQ_W'(1);
                    head_next = wrap_slot(head_sum);
                    infl_next = infl_reg - IF_W'(ack_span);
                    dup_next  = '0;
                    if (infl_reg != IF_W'(ack_span))
                    begin
                        timer_cmd_next = TIMER_START;
                        timer_seq_next = cmd.ack + SEQ_W'(1);
                    end
                    else
                    begin
                        timer_cmd_next = TIMER_STOP;
                    end
                end
            end
            CMD_TIMEOUT:
            begin
                if (infl_reg != '0)
                begin
                    tx_valid_next  = 1'b1;
                    tx_seq_next    = base_reg;
                    resend         = 1'b1;
                    timer_cmd_next = TIMER_START;
                    timer_seq_next = base_reg;
                end
            end
            default:
            begin
            end
        endcase

        full_next = (infl_next >= eff_limit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            nseq_reg      <= '0;
            infl_reg      <= '0;
            dup_reg       <= '0;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                base_reg <= base_next;
                nseq_reg <= nseq_next;
                infl_reg <= infl_next;
                dup_reg  <= dup_next;
                head_reg <= head_next;
            end
            if (take)
                out_valid_reg <= 1'b1;
            else if (egress.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && store_we)
            store_mem[store_slot] <= cmd_payload;
    end

    // A resend reads the oldest stored payload straight into the result register
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            accepted_reg   <= accepted_next;
            tx_valid_reg   <= tx_valid_next;
            tx_seq_reg     <= tx_seq_next;
            tx_payload_reg <= resend ? store_mem[head_reg] : tx_payload_next;
            timer_cmd_reg  <= timer_cmd_next;
            timer_seq_reg  <= timer_seq_next;
            full_reg       <= full_next;
        end
    end

    // Base and next sequence are the live state, which equals the state after
    // the held result: nothing is taken while the result waits.
    assign egress.valid       = out_valid_reg;
    assign egress.accepted    = accepted_reg;
    assign egress.tx_valid    = tx_valid_reg;
    assign egress.tx_seq      = tx_seq_reg;
    assign egress.tx_payload  = tx_payload_reg;
    assign egress.timer_cmd   = timer_cmd_reg;
    assign egress.timer_seq   = timer_seq_reg;
    assign egress.window_full = full_reg;
    assign egress.window_base = base_reg;
    assign egress.next_seq    = nseq_reg;

endmodule

// ===== rtl/sliding_window_sender_fast_retransmit.sv =====
// Go-back-N sender with fast retransmit: top level.
// An accepted beat is written into the command queue, then taken by the back end
// into the result register. Throughput: one beat per cycle while egress.ready is
// held high; a two-entry command queue and the result register decouple the sides.
// Reset (rst_n, asynchronous, active low): empty window, base and next sequence
// zero, window limit 4, duplicate threshold 3; the payload store is not cleared.
`timescale 1ns / 1ps

module sliding_window_sender_fast_retransmit #(
    parameter int WINDOW       = 4,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [swsfr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [swsfr_pkg::CFG_DATA_W-1:0]     cfg_data,
    swsfr_in_if.sink                             ingress,
    swsfr_out_if.source                          egress
);
    import swsfr_pkg::*;

    // Configuration registers; must be written by the user only while the block is idle (the
    // block itself does not enforce this), so the back end reads them directly without any shadowing.
    logic [LIMIT_W-1:0] window_limit_reg;
    logic [THR_W-1:0]   dup_threshold_reg;
    cfg_t               cfg;

    // Front-to-back command beat
    cmd_t                    cmd;
    logic [PAYLOAD_BITS-1:0] cmd_payload;
    logic                    cmd_valid;
    logic                    cmd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_limit_reg  <= LIMIT_RESET;
            dup_threshold_reg <= THR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WINDOW_LIMIT:  window_limit_reg  <= cfg_data;
                CFG_DUP_THRESHOLD: dup_threshold_reg <= cfg_data[THR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.window_limit      = window_limit_reg;
    assign cfg.dup_ack_threshold = dup_threshold_reg;

    // Decode incoming events and queue them
    swsfr_front #(
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .ingress     (ingress),
        .cmd         (cmd),
        .cmd_payload (cmd_payload),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready)
    );

    // Apply each command to the window and hold the result until taken
    swsfr_back #(
        .WINDOW       (WINDOW),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cmd         (cmd),
        .cmd_payload (cmd_payload),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .egress      (egress)
    );

endmodule

// ===== rtl/swsfr_checker.sv =====
// Port-level checker for the go-back-N sender, bound to the top level.
// Depends on swsfr_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "sliding_window_sender_fast_retransmit_defines.svh"

module swsfr_checker #(
    parameter int PAYLOAD_BITS = 64
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               out_valid,
    input logic                               accepted,
    input logic                               tx_valid,
    input logic [swsfr_pkg::SEQ_W-1:0]        tx_seq,
    input logic [PAYLOAD_BITS-1:0]            tx_payload,
    input logic [swsfr_pkg::TIMER_W-1:0]      timer_cmd,
    input logic [swsfr_pkg::SEQ_W-1:0]        timer_seq
);
    import swsfr_pkg::*;

    logic tx_idle;
    logic tseq_idle;
    logic no_start;
    logic send_ok;

    assign tx_idle   = (tx_seq == '0) && (tx_payload == '0);
    assign tseq_idle = (timer_seq == '0);
    assign no_start  = out_valid && (timer_cmd != TIMER_START);
    // A taken send always transmits and never stops the timer; a start is for it
    assign send_ok   = tx_valid && (timer_cmd != TIMER_STOP)
                       && (timer_cmd != TIMER_START || timer_seq == tx_seq);

    // No result beat while reset is held
    `SWSFR_ASSERT_RST(a_no_beat_in_reset, !rst_n |-> !out_valid, "result beat during reset")

    // Idle transmit fields read as zero
    `SWSFR_ASSERT_CLK(a_idle_tx_zero, out_valid && !tx_valid |-> tx_idle, "stray transmit fields")

    // Timer sequence only carries a value on a start
    `SWSFR_ASSERT_CLK(a_timer_seq_zero, no_start |-> tseq_idle, "stray timer sequence")

    `SWSFR_ASSERT_CLK(a_send_tx, out_valid && accepted |-> send_ok, "send not transmitted")

endmodule

bind sliding_window_sender_fast_retransmit swsfr_checker #(
    .PAYLOAD_BITS (PAYLOAD_BITS)
) u_swsfr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (egress.valid),
    .accepted   (egress.accepted),
    .tx_valid   (egress.tx_valid),
    .tx_seq     (egress.tx_seq),
    .tx_payload (egress.tx_payload),
    .timer_cmd  (egress.timer_cmd),
    .timer_seq  (egress.timer_seq)
);
